### hw/rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg: shared types and constants
// Command codes, queue item layout and widths for the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int DELAY_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int OP_W        = 3;
  localparam int BIT_IDX_W   = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd10;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 1'd0;

  // raw op field codes
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // one classified tick, as it travels from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } item_t;

endpackage

### hw/rtl/i2cbm_if.sv
// ----------------------------------------------------------------------------
// i2cbm channel interfaces
// Valid/ready channels for input ticks and result ticks.
// ----------------------------------------------------------------------------
interface i2cbm_in_if;
  logic                           valid;
  logic                           ready;
  logic [i2cbm_pkg::OP_W-1:0]     op;
  logic [i2cbm_pkg::BYTE_W-1:0]   tx_byte;
  logic                           send_ack;
  logic                           sda_in;

  modport source (output valid, op, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cbm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           scl_low;
  logic                           sda_low;
  logic                           busy_res;
  logic                           done_res;
  logic [i2cbm_pkg::BYTE_W-1:0]   rx_byte;
  logic                           nack;

  modport source (output valid, scl_low, sda_low, busy_res, done_res, rx_byte, nack,
                  input ready);
  modport sink   (input valid, scl_low, sda_low, busy_res, done_res, rx_byte, nack,
                  output ready);
endinterface

### hw/rtl/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front: input classifier
// Accepts input ticks and decodes the op field into a command.
// ----------------------------------------------------------------------------
module i2cbm_front (
  i2cbm_in_if.sink          in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output i2cbm_pkg::item_t  push_item
);

  i2cbm_pkg::cmd_t cmd;

  // unknown op codes behave as no command
  always_comb begin
    unique case (in_ch.op)
      i2cbm_pkg::OP_START: cmd = i2cbm_pkg::CMD_START;
      i2cbm_pkg::OP_STOP:  cmd = i2cbm_pkg::CMD_STOP;
      i2cbm_pkg::OP_WRITE: cmd = i2cbm_pkg::CMD_WRITE;
      i2cbm_pkg::OP_READ:  cmd = i2cbm_pkg::CMD_READ;
      default:             cmd = i2cbm_pkg::CMD_NONE;
    endcase
  end

  assign push_valid         = in_ch.valid;
  assign in_ch.ready        = push_ready;
  assign push_item.cmd      = cmd;
  assign push_item.tx_byte  = in_ch.tx_byte;
  assign push_item.send_ack = in_ch.send_ack;
  assign push_item.sda_in   = in_ch.sda_in;

endmodule

### hw/rtl/i2cbm_queue.sv
// ----------------------------------------------------------------------------
// i2cbm_queue: two-entry item queue
// Decouples the classifier from the bus engine.
// ----------------------------------------------------------------------------
module i2cbm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  i2cbm_pkg::item_t  push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output i2cbm_pkg::item_t  pop_item
);

  i2cbm_pkg::item_t                 mem_r [i2cbm_pkg::QUEUE_DEPTH];
  logic [i2cbm_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [i2cbm_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                             push, pop;

  assign push_ready = (cnt_r != i2cbm_pkg::QCNT_W'(i2cbm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/i2cbm_back.sv
// ----------------------------------------------------------------------------
// i2cbm_back: bus sequencer
// Runs one line action per tick and registers the result.
// ----------------------------------------------------------------------------
module i2cbm_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [i2cbm_pkg::DELAY_W-1:0]    delay_ticks,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  i2cbm_pkg::item_t                 pop_item,
  i2cbm_out_if.source                      out_ch
);

  localparam int PH_N = 29;

  typedef enum logic [PH_N-1:0] {
    P_IDLE    = 29'd1 << 0,
    P_S_SDA   = 29'd1 << 1,
    P_S_DLY   = 29'd1 << 2,
    P_S_SCL   = 29'd1 << 3,
    P_P_SDA   = 29'd1 << 4,
    P_P_DLY1  = 29'd1 << 5,
    P_P_SCL   = 29'd1 << 6,
    P_P_DLY2  = 29'd1 << 7,
    P_P_REL   = 29'd1 << 8,
    P_W_BIT   = 29'd1 << 9,
    P_W_DLY1  = 29'd1 << 10,
    P_W_SCLH  = 29'd1 << 11,
    P_W_DLY2  = 29'd1 << 12,
    P_W_SCLL  = 29'd1 << 13,
    P_W_REL   = 29'd1 << 14,
    P_W_DLY3  = 29'd1 << 15,
    P_W_ACKH  = 29'd1 << 16,
    P_W_DLY4  = 29'd1 << 17,
    P_W_SAMP  = 29'd1 << 18,
    P_R_SCLH  = 29'd1 << 19,
    P_R_DLY1  = 29'd1 << 20,
    P_R_SAMP  = 29'd1 << 21,
    P_R_DLY2  = 29'd1 << 22,
    P_R_ACK   = 29'd1 << 23,
    P_R_SCLH2 = 29'd1 << 24,
    P_R_DLY3  = 29'd1 << 25,
    P_R_SCLL  = 29'd1 << 26,
    P_R_DLY4  = 29'd1 << 27,
    P_R_REL   = 29'd1 << 28
  } phase_t;

  phase_t                              phase_r, phase_nxt, ph;
  logic                                scl_r, scl_nxt, sda_r, sda_nxt;
  logic [i2cbm_pkg::BIT_IDX_W-1:0]     bit_r, bit_nxt, bit_cur;
  logic [i2cbm_pkg::DELAY_W-1:0]       hold_r, hold_nxt, hold_cur, hold_inc, limit;
  logic [i2cbm_pkg::BYTE_W-1:0]        shift_r, shift_nxt, shift_cur;
  logic [i2cbm_pkg::BYTE_W-1:0]        rx_r, rx_nxt;
  logic                                ack_flag_r, ack_flag_nxt;
  logic                                ack_send_r, ack_send_nxt;
  logic                                fire, busy, done;
  logic                                step;
  logic                                out_valid_r;
  logic                                o_busy_r, o_done_r;

  // advance whenever an item is queued and the output register is free or being drained
  assign step      = pop_valid && (!out_valid_r || out_ch.ready);
  assign pop_ready = step;

  assign limit    = (delay_ticks == '0) ? i2cbm_pkg::DELAY_W'(1) : delay_ticks;
  assign hold_inc = hold_cur + 1'b1;
  assign fire     = (hold_inc >= limit);

  always_comb begin
    ph           = phase_r;
    bit_cur      = bit_r;
    hold_cur     = hold_r;
    shift_cur    = shift_r;
    ack_send_nxt = ack_send_r;
    // a command given while idle runs its first action in this same tick
    if (phase_r == P_IDLE) begin
      case (pop_item.cmd)
        i2cbm_pkg::CMD_START: ph = P_S_SDA;
        i2cbm_pkg::CMD_STOP:  ph = P_P_SDA;
        i2cbm_pkg::CMD_WRITE: begin
          ph        = P_W_BIT;
          shift_cur = pop_item.tx_byte;
        end
        i2cbm_pkg::CMD_READ: begin
          ph           = P_R_SCLH;
          shift_cur    = '0;
          ack_send_nxt = pop_item.send_ack;
        end
        default: ph = P_IDLE;
      endcase
      if (ph != P_IDLE) begin
        bit_cur  = '1;
        hold_cur = '0;
      end
    end
  end

  always_comb begin
    phase_nxt    = ph;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    bit_nxt      = bit_cur;
    hold_nxt     = hold_cur;
    shift_nxt    = shift_cur;
    rx_nxt       = rx_r;
    ack_flag_nxt = ack_flag_r;
    done         = 1'b0;
    busy         = (ph != P_IDLE);
    unique case (ph)
      P_IDLE: ;
      P_S_SDA: begin
        sda_nxt   = 1'b1;
        phase_nxt = P_S_DLY;
      end
      P_S_SCL: begin
        scl_nxt = 1'b1;
        done    = 1'b1;
      end
      P_P_SDA: begin
        sda_nxt   = 1'b1;
        phase_nxt = P_P_DLY1;
      end
      P_P_SCL: begin
        scl_nxt   = 1'b0;
        phase_nxt = P_P_DLY2;
      end
      P_P_REL: begin
        sda_nxt = 1'b0;
        done    = 1'b1;
      end
      P_W_BIT: begin
        sda_nxt   = ~shift_cur[bit_cur];
        phase_nxt = P_W_DLY1;
      end
      P_W_SCLH: begin
        scl_nxt   = 1'b0;
        phase_nxt = P_W_DLY2;
      end
      P_W_SCLL: begin
        scl_nxt = 1'b1;
        if (bit_cur == '0) begin
          phase_nxt = P_W_REL;
        end else begin
          bit_nxt   = bit_cur - 1'b1;
          phase_nxt = P_W_BIT;
        end
      end
      P_W_REL: begin
        sda_nxt   = 1'b0;
        phase_nxt = P_W_DLY3;
      end
      P_W_ACKH: begin
        scl_nxt   = 1'b0;
        phase_nxt = P_W_DLY4;
      end
      P_W_SAMP: begin
        ack_flag_nxt = pop_item.sda_in;
        scl_nxt      = 1'b1;
        done         = 1'b1;
      end
      P_R_SCLH: begin
        scl_nxt   = 1'b0;
        phase_nxt = P_R_DLY1;
      end
      P_R_SAMP: begin
        if (pop_item.sda_in) begin
          shift_nxt[bit_cur] = 1'b1;
        end
        scl_nxt   = 1'b1;
        phase_nxt = P_R_DLY2;
      end
      P_R_DLY2: begin
        hold_nxt = fire ? '0 : hold_inc;
        if (fire) begin
          if (bit_cur == '0) begin
            phase_nxt = P_R_ACK;
          end else begin
            bit_nxt   = bit_cur - 1'b1;
            phase_nxt = P_R_SCLH;
          end
        end
      end
      P_R_ACK: begin
        sda_nxt   = ack_send_nxt;
        phase_nxt = P_R_SCLH2;
      end
      P_R_SCLH2: begin
        scl_nxt   = 1'b0;
        phase_nxt = P_R_DLY3;
      end
      P_R_SCLL: begin
        scl_nxt   = 1'b1;
        phase_nxt = P_R_DLY4;
      end
      P_R_REL: begin
        sda_nxt = 1'b0;
        rx_nxt  = shift_cur;
        done    = 1'b1;
      end
      // plain bus delays: hold both lines, then move on
      P_S_DLY, P_P_DLY1, P_P_DLY2, P_W_DLY1, P_W_DLY2, P_W_DLY3, P_W_DLY4,
      P_R_DLY1, P_R_DLY3, P_R_DLY4: begin
        hold_nxt = fire ? '0 : hold_inc;
        if (fire) begin
          unique case (ph)
            P_S_DLY:  phase_nxt = P_S_SCL;
            P_P_DLY1: phase_nxt = P_P_SCL;
            P_P_DLY2: phase_nxt = P_P_REL;
            P_W_DLY1: phase_nxt = P_W_SCLH;
            P_W_DLY2: phase_nxt = P_W_SCLL;
            P_W_DLY3: phase_nxt = P_W_ACKH;
            P_W_DLY4: phase_nxt = P_W_SAMP;
            P_R_DLY1: phase_nxt = P_R_SAMP;
            P_R_DLY3: phase_nxt = P_R_SCLL;
            P_R_DLY4: phase_nxt = P_R_REL;
            default:  phase_nxt = P_IDLE;
          endcase
        end
      end
      default: phase_nxt = P_IDLE;
    endcase
    if (done) begin
      phase_nxt = P_IDLE;
      bit_nxt   = '1;
      hold_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      bit_r       <= '1;
      hold_r      <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      ack_flag_r  <= 1'b0;
      ack_send_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r    <= phase_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        bit_r      <= bit_nxt;
        hold_r     <= hold_nxt;
        shift_r    <= shift_nxt;
        rx_r       <= rx_nxt;
        ack_flag_r <= ack_flag_nxt;
        ack_send_r <= ack_send_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_busy_r <= busy;
      o_done_r <= done;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scl_low  = scl_r;
  assign out_ch.sda_low  = sda_r;
  assign out_ch.busy_res = o_busy_r;
  assign out_ch.done_res = o_done_r;
  assign out_ch.rx_byte  = rx_r;
  assign out_ch.nack     = ack_flag_r;

endmodule

### hw/rtl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master: open-drain I2C master bit engine
// Start, stop, byte write and byte read sequences, one bus tick per item.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake     | carries
//  ---------+-----------+---------------+----------------------------------------
//  in_ch    | in        | valid/ready   | op, tx_byte, send_ack, sda_in
//  out_ch   | out       | valid/ready   | scl_low, sda_low, busy_res, done_res,
//           |           |               | rx_byte, nack
//  cfg_*    | in        | APB, pready=1 | delay_ticks at byte address 0
//
// Rate: one tick per clock sustained while the output is not blocked; each
// result passes through the item queue and then the output register.
// The sequencer advances one phase per transfer, so the rate does not
// depend on the bus delay.
// Reset: delay_ticks returns to 10, both lines released, sequencer idle.
// Stalls: a blocked output holds the sequencer; the two-entry queue keeps
// taking input until it fills.
//
module i2c_bit_level_master (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cbm_in_if.sink                            in_ch,
  i2cbm_out_if.source                         out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2cbm_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [i2cbm_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [i2cbm_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);

  logic [i2cbm_pkg::DELAY_W-1:0]   delay_r;
  logic [i2cbm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                            cfg_wr;
  logic                            push_valid, push_ready;
  logic                            pop_valid, pop_ready;
  i2cbm_pkg::item_t                push_item, pop_item;

  // register index is the word address
  assign cfg_idx    = cfg_paddr[i2cbm_pkg::CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= i2cbm_pkg::DELAY_RESET;
    end else if (cfg_wr && (cfg_idx == i2cbm_pkg::REG_DELAY)) begin
      delay_r <= cfg_pwdata[i2cbm_pkg::DELAY_W-1:0];
    end
  end

  // unmapped addresses read back as zero
  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == i2cbm_pkg::REG_DELAY) begin
      cfg_prdata = i2cbm_pkg::CFG_DW'(delay_r);
    end
  end

  // classify each tick as it arrives
  i2cbm_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // buffer classified ticks between front and sequencer
  i2cbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // drive the bus lines, one action per transfer
  i2cbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delay_ticks (delay_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_ch      (out_ch)
  );

endmodule

### bench/i2c_bit_level_master_test.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_test: self-checking bench for the I2C bit engine
// Drives bus ticks through the input channel, predicts the line levels and
// status of every tick with a cycle model of the engine, and compares each
// result transfer field by field. Covers several bus delays, commands given
// while busy, spare op codes, random bursts and long output stalls.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_test;
  import i2cbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int DRAIN_PAUSE    = 8;     // settle pause, padded past the item queue and output register
  localparam int LONG_HOLD      = 300;   // receiver hold-off, well past queue depth
  localparam int MAX_REPORTS    = 40;

  // spare op codes: the engine must treat these like no command
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // how the directed part drives sda_in while a command runs
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam logic [CFG_AW-1:0] DELAY_ADDR = CFG_AW'({REG_DELAY, 2'b00});

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tx;
    logic              ack;
    logic              sda;
  } tick_t;

  typedef struct packed {
    logic              scl_low;
    logic              sda_low;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack;
  } levels_t;

  // one step of a command sequence per bus tick
  typedef enum logic [4:0] {
    PH_IDLE,
    ST_SDA_LOW, ST_HOLD, ST_SCL_LOW,
    SP_SDA_LOW, SP_HOLD1, SP_SCL_REL, SP_HOLD2, SP_SDA_REL,
    WR_DATA, WR_HOLD1, WR_SCL_REL, WR_HOLD2, WR_SCL_LOW,
    WR_SDA_REL, WR_HOLD3, WR_ACK_SCL, WR_HOLD4, WR_ACK_SAMPLE,
    RD_SCL_REL, RD_HOLD1, RD_SAMPLE, RD_HOLD2,
    RD_ACK_DRIVE, RD_ACK_SCL, RD_HOLD3, RD_ACK_SCL_LOW, RD_HOLD4, RD_SDA_REL
  } bus_phase_e;

  // Line model of the engine plus the queue of line levels still owed.
  class line_tracker;
    logic [DELAY_W-1:0]   delay_cfg;
    bus_phase_e           ph;
    logic                 scl_q, sda_q, nack_q, ack_pend;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [DELAY_W-1:0]   hold_cnt;
    logic [BYTE_W-1:0]    shift_q, rx_q;
    levels_t              owed_q[$];
    int                   errors, checked, ticks;
    int                   launched[8];

    function new();
      delay_cfg = DELAY_RESET;
      ph        = PH_IDLE;
      scl_q     = 1'b0;
      sda_q     = 1'b0;
      nack_q    = 1'b0;
      ack_pend  = 1'b0;
      bit_idx   = '1;
      hold_cnt  = '0;
      shift_q   = '0;
      rx_q      = '0;
      errors    = 0;
      checked   = 0;
      ticks     = 0;
      foreach (launched[k]) launched[k] = 0;
    endfunction

    function void set_delay(input logic [DELAY_W-1:0] value);
      delay_cfg = value;
    endfunction

    function bit engine_idle();
      return ph == PH_IDLE;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // count one tick of a bus delay; a zero delay counts as one tick
    function bit hold_over();
      logic [DELAY_W-1:0] lim;
      lim      = (delay_cfg == '0) ? DELAY_W'(1) : delay_cfg;
      hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt >= lim) begin
        hold_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_tick(input tick_t t);
      levels_t w;
      logic    fin;
      fin = 1'b0;
      ticks++;
      if (ph == PH_IDLE) begin
        case (t.op)
          OP_START: ph = ST_SDA_LOW;
          OP_STOP:  ph = SP_SDA_LOW;
          OP_WRITE: begin
            shift_q = t.tx;
            ph      = WR_DATA;
          end
          OP_READ: begin
            shift_q  = '0;
            ack_pend = t.ack;
            ph       = RD_SCL_REL;
          end
          default: ;
        endcase
        if (ph != PH_IDLE) begin
          hold_cnt = '0;
          bit_idx  = '1;
          launched[t.op]++;
        end
      end
      w.busy = (ph != PH_IDLE);
      case (ph)
        ST_SDA_LOW: begin
          sda_q = 1'b1;
          ph    = ST_HOLD;
        end
        ST_HOLD:    if (hold_over()) ph = ST_SCL_LOW;
        ST_SCL_LOW: begin
          scl_q = 1'b1;
          fin   = 1'b1;
        end
        SP_SDA_LOW: begin
          sda_q = 1'b1;
          ph    = SP_HOLD1;
        end
        SP_HOLD1:   if (hold_over()) ph = SP_SCL_REL;
        SP_SCL_REL: begin
          scl_q = 1'b0;
          ph    = SP_HOLD2;
        end
        SP_HOLD2:   if (hold_over()) ph = SP_SDA_REL;
        SP_SDA_REL: begin
          sda_q = 1'b0;
          fin   = 1'b1;
        end
        WR_DATA: begin
          sda_q = ~shift_q[bit_idx];
          ph    = WR_HOLD1;
        end
        WR_HOLD1:   if (hold_over()) ph = WR_SCL_REL;
        WR_SCL_REL: begin
          scl_q = 1'b0;
          ph    = WR_HOLD2;
        end
        WR_HOLD2:   if (hold_over()) ph = WR_SCL_LOW;
        WR_SCL_LOW: begin
          scl_q = 1'b1;
          if (bit_idx == '0) begin
            ph = WR_SDA_REL;
          end else begin
            bit_idx = bit_idx - 1'b1;
            ph      = WR_DATA;
          end
        end
        WR_SDA_REL: begin
          sda_q = 1'b0;
          ph    = WR_HOLD3;
        end
        WR_HOLD3:   if (hold_over()) ph = WR_ACK_SCL;
        WR_ACK_SCL: begin
          scl_q = 1'b0;
          ph    = WR_HOLD4;
        end
        WR_HOLD4:   if (hold_over()) ph = WR_ACK_SAMPLE;
        WR_ACK_SAMPLE: begin
          nack_q = t.sda;
          scl_q  = 1'b1;
          fin    = 1'b1;
        end
        RD_SCL_REL: begin
          scl_q = 1'b0;
          ph    = RD_HOLD1;
        end
        RD_HOLD1:   if (hold_over()) ph = RD_SAMPLE;
        RD_SAMPLE: begin
          if (t.sda) shift_q[bit_idx] = 1'b1;
          scl_q = 1'b1;
          ph    = RD_HOLD2;
        end
        RD_HOLD2: begin
          if (hold_over()) begin
            if (bit_idx == '0) begin
              ph = RD_ACK_DRIVE;
            end else begin
              bit_idx = bit_idx - 1'b1;
              ph      = RD_SCL_REL;
            end
          end
        end
        RD_ACK_DRIVE: begin
          sda_q = ack_pend;
          ph    = RD_ACK_SCL;
        end
        RD_ACK_SCL: begin
          scl_q = 1'b0;
          ph    = RD_HOLD3;
        end
        RD_HOLD3:   if (hold_over()) ph = RD_ACK_SCL_LOW;
        RD_ACK_SCL_LOW: begin
          scl_q = 1'b1;
          ph    = RD_HOLD4;
        end
        RD_HOLD4:   if (hold_over()) ph = RD_SDA_REL;
        RD_SDA_REL: begin
          sda_q = 1'b0;
          rx_q  = shift_q;
          fin   = 1'b1;
        end
        default: ;
      endcase
      if (fin) begin
        ph       = PH_IDLE;
        bit_idx  = '1;
        hold_cnt = '0;
      end
      w.scl_low = scl_q;
      w.sda_low = sda_q;
      w.done    = fin;
      w.rx_byte = rx_q;
      w.nack    = nack_q;
      owed_q.push_back(w);
    endfunction

    function void compare_field(input string name, input logic [BYTE_W-1:0] got,
                                input logic [BYTE_W-1:0] want);
      if (got !== want)
        flag_error($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
    endfunction

    function void check_levels(input levels_t got);
      levels_t w;
      if (owed_q.size() == 0) begin
        flag_error($sformatf("result with no tick pending: %p", got));
        return;
      end
      w = owed_q.pop_front();
      compare_field("scl_low", got.scl_low, w.scl_low);
      compare_field("sda_low", got.sda_low, w.sda_low);
      compare_field("busy_res", got.busy, w.busy);
      compare_field("done_res", got.done, w.done);
      compare_field("rx_byte", got.rx_byte, w.rx_byte);
      compare_field("nack", got.nack, w.nack);
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  i2cbm_in_if  in_if();
  i2cbm_out_if out_if();

  i2c_bit_level_master u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  line_tracker trk = new();

  // pacing controls shared between the stimulus and the receiver
  bit      steady    = 1'b0;  // no gaps on either side while set
  bit      stall_req = 1'b0;  // ask the receiver for one long hold-off
  bit      bus_open  = 1'b0;  // a start has been sent and no stop yet
  int      burst_left = 0;
  int      quiet_cycles = 0;
  levels_t seen_lv;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Insert a random gap between bursts; stay back-to-back while steady.
  task automatic pace_sender();
    int gap;
    if (steady) return;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
  endtask

  // Offer one tick and hold it until the block takes the transfer.
  task automatic push_tick(input tick_t t);
    pace_sender();
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.op       <= t.op;
    in_if.tx_byte  <= t.tx;
    in_if.send_ack <= t.ack;
    in_if.sda_in   <= t.sda;
    do @(posedge clk); while (!in_if.ready);
    trk.note_tick(t);
  endtask

  function automatic tick_t idle_tick();
    tick_t t;
    t.op  = OP_NONE;
    t.tx  = BYTE_W'($urandom);
    t.ack = 1'($urandom_range(0, 1));
    t.sda = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic logic pick_sda(input int mode);
    if (mode == SDA_LOW)  return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // Give one command, then tick until the engine is idle again. The first busy
  // tick carries busy_op, which the engine must ignore.
  task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                       input logic ack, input int sda_mode,
                       input logic [OP_W-1:0] busy_op);
    tick_t t;
    bit    first;
    t     = idle_tick();
    t.op  = op;
    t.tx  = tx;
    t.ack = ack;
    t.sda = pick_sda(sda_mode);
    push_tick(t);
    first = 1'b1;
    while (!trk.engine_idle()) begin
      t     = idle_tick();
      t.sda = pick_sda(sda_mode);
      if (first) t.op = busy_op;
      first = 1'b0;
      push_tick(t);
    end
  endtask

  // Mostly well-formed transactions (start, bytes, stop) with random data,
  // plus noise: stray ops while busy, spare codes, broken sequences.
  function automatic tick_t random_tick();
    tick_t t;
    int    roll;
    t = idle_tick();
    if ($urandom_range(0, 7) == 0) t.tx = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    roll = $urandom_range(0, 99);
    if (!trk.engine_idle()) begin
      if (roll < 15) t.op = OP_W'($urandom_range(0, 7));
    end else if (roll < 8) begin
      t.op = OP_W'($urandom_range(0, 7));
    end else if (!bus_open) begin
      if (roll < 85) begin
        t.op     = OP_START;
        bus_open = 1'b1;
      end
    end else if (roll < 45) begin
      t.op = OP_WRITE;
    end else if (roll < 75) begin
      t.op = OP_READ;
    end else if (roll < 90) begin
      t.op     = OP_STOP;
      bus_open = 1'b0;
    end else if (roll < 95) begin
      t.op = OP_START;  // repeated start
    end
    return t;
  endfunction

  // Send n random ticks, then idle ticks until the running command finishes.
  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) push_tick(random_tick());
    while (!trk.engine_idle()) push_tick(idle_tick());
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  task automatic check_delay_reg(input logic [DELAY_W-1:0] want);
    logic [CFG_DW-1:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= DELAY_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[DELAY_W-1:0] !== want)
      trk.flag_error($sformatf("delay_ticks reads %0h, expected %0h", rd[DELAY_W-1:0], want));
  endtask

  // Write delay_ticks with random upper bus bits, which the register drops.
  task automatic set_bus_delay(input logic [DELAY_W-1:0] value);
    logic [CFG_DW-1:0] data;
    data = {CFG_DW'($urandom)} << DELAY_W;
    data[DELAY_W-1:0] = value;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DELAY_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    trk.set_delay(value);
    check_delay_reg(value);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, sample results at the rising edge
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int len;
    int k;
    out_if.ready = 1'b0;
    forever begin
      if (stall_req) begin
        // hold off long enough for the input queue to fill and stall the sender
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_req = 1'b0;
      end else if (steady) begin
        @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 40);
        for (k = 0; k < len; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= (k % 3 == 0);
            default: out_if.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_lv.scl_low = out_if.scl_low;
      seen_lv.sda_low = out_if.sda_low;
      seen_lv.busy    = out_if.busy_res;
      seen_lv.done    = out_if.done_res;
      seen_lv.rx_byte = out_if.rx_byte;
      seen_lv.nack    = out_if.nack;
      trk.check_levels(seen_lv);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("i2c_bit_level_master verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_NONE;
    in_if.tx_byte  = '0;
    in_if.send_ack = 1'b0;
    in_if.sda_in   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value of the delay register, then random traffic at that delay
    check_delay_reg(DELAY_RESET);
    run_random(100);
    settle();

    // directed: shortest delay, extreme bytes, both ack levels, ignored ops
    set_bus_delay(DELAY_W'(1));
    push_tick(idle_tick());
    for (logic [OP_W-1:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST;
         op++) begin
      issue(op, 8'hFF, 1'b1, SDA_RANDOM, OP_NONE);
    end
    issue(OP_START, 8'h00, 1'b0, SDA_RANDOM, OP_STOP);
    issue(OP_WRITE, 8'hFF, 1'b0, SDA_HIGH, OP_READ);       // slave nacks
    issue(OP_WRITE, 8'h00, 1'b1, SDA_LOW, OP_START);       // slave acks
    issue(OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM, OP_SPARE_LAST);
    issue(OP_READ, 8'h00, 1'b1, SDA_HIGH, OP_WRITE);       // all ones, ack
    issue(OP_READ, 8'hFF, 1'b0, SDA_LOW, OP_STOP);         // all zeros, nack
    issue(OP_READ, 8'hA5, 1'b1, SDA_RANDOM, OP_READ);
    issue(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, OP_WRITE);
    issue(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, OP_NONE);      // stop with no start
    issue(OP_READ, 8'h00, 1'b0, SDA_RANDOM, OP_NONE);      // read with no start
    settle();

    // zero delay acts as one tick; hold the receiver off once in this phase
    set_bus_delay(DELAY_W'(0));
    stall_req = 1'b1;
    run_random(300);
    settle();

    set_bus_delay(DELAY_W'(2));
    run_random(250);
    settle();

    set_bus_delay(DELAY_W'(3));
    run_random(250);
    settle();

    set_bus_delay(DELAY_W'(1));
    run_random(250);
    settle();

    // full-width register write and read back, then one long start gap-free
    steady = 1'b1;
    set_bus_delay('1);
    set_bus_delay(DELAY_W'(120));
    issue(OP_START, 8'h00, 1'b0, SDA_RANDOM, OP_WRITE);
    settle();
    steady = 1'b0;

    if (trk.pending() != 0)
      trk.flag_error($sformatf("%0d results never arrived", trk.pending()));

    $display("Run covered %0d bus ticks and %0d checked results: %0d start, %0d stop,",
             trk.ticks, trk.checked, trk.launched[OP_START], trk.launched[OP_STOP]);
    $display("%0d write, %0d read commands over bus delays 10, 1, 0, 2, 3 and 120",
             trk.launched[OP_WRITE], trk.launched[OP_READ]);
    if (trk.errors == 0) begin
      $display("i2c_bit_level_master verification clean");
    end else begin
      $display("i2c_bit_level_master verification failed");
    end
    $finish;
  end

endmodule
